FILE: design/sdf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared constants and types of the substring delete filter.
// ----------------------------------------------------------------------------
package sdf_pkg;

  localparam int PATTERN_MAX = 8;
  localparam int CNT_W       = $clog2(PATTERN_MAX + 1);
  localparam int SLOT_W      = $clog2(PATTERN_MAX);
  localparam int SUM_W       = $clog2(2 * PATTERN_MAX);
  localparam int CFG_W       = 64;
  localparam int LEN_W       = 4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [7:0] char_t;

  typedef enum logic {
    REG_PATTERN_BYTES  = 1'b0,
    REG_PATTERN_LENGTH = 1'b1
  } reg_index_t;

  typedef struct packed {
    char_t text_char;
    logic  is_last;
  } in_item_t;

  typedef struct packed {
    char_t out_char;
    logic  char_valid;
    logic  end_of_text;
  } result_t;

endpackage
`default_nettype wire

FILE: design/sdf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdf_front
// Input queue that takes characters from the producer and hands them to the
// scan engine in order.
// ----------------------------------------------------------------------------
module sdf_front import sdf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_en,
  input  in_item_t wr_item,
  output logic     full,
  output logic     avail,
  input  logic     rd_en,
  output in_item_t rd_item
);

  in_item_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_wr;
  logic                do_rd;

  always_comb begin
    full    = (count == QCNT_W'(QUEUE_DEPTH));
    avail   = (count != '0);
    do_wr   = wr_en && !full;
    do_rd   = rd_en && avail;
    rd_item = slots[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_item;
    end
  end

endmodule
`default_nettype wire

FILE: design/sdf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdf_back
// Scan engine: holds the pending window, compares it with the pattern, drops
// matches and sends kept characters through a one-result hold stage that
// marks the end of each text.
// ----------------------------------------------------------------------------
module sdf_back import sdf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [PATTERN_MAX*8-1:0] pattern_bytes,
  input  logic [CNT_W-1:0]         pattern_len,
  input  logic                     in_avail,
  input  in_item_t                 in_item,
  output logic                     in_pop,
  output logic                     res_push,
  output result_t                  res_item,
  input  logic                     res_full
);

  char_t              win [PATTERN_MAX];
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic               item_last;
  logic               item_emitted;
  result_t            hold;
  logic               hold_valid;
  logic               hold_final;

  char_t              cur_win [PATTERN_MAX];
  char_t              win_next [PATTERN_MAX];
  logic [CNT_W-1:0]   cur_cnt;
  logic [CNT_W-1:0]   cnt_next;
  logic [CNT_W-1:0]   sh;
  logic [SUM_W-1:0]   src;
  logic               active;
  logic               last_now;
  logic               emitted_before;
  logic               match;
  logic               emit_char;
  logic               empty_mark;
  logic               emit;
  logic               more;
  logic               done;
  logic               push_need;
  logic               stall;
  logic               advance;
  result_t            emit_item;

  always_comb begin
    active         = busy || in_avail;
    last_now       = busy ? item_last : in_item.is_last;
    emitted_before = busy && item_emitted;
    cur_cnt        = busy ? cnt : cnt + 1'b1;

    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (!busy && (cnt[SLOT_W-1:0] == SLOT_W'(i))) begin
        cur_win[i] = in_item.text_char;
      end else begin
        cur_win[i] = win[i];
      end
    end

    match = 1'b1;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if ((CNT_W'(i) < pattern_len) && (cur_win[i] != pattern_bytes[i*8 +: 8])) begin
        match = 1'b0;
      end
    end

    emit_char = 1'b0;
    sh        = '0;
    if (pattern_len == '0) begin
      if (cur_cnt != '0) begin
        emit_char = 1'b1;
        sh        = CNT_W'(1);
      end
    end else if (cur_cnt >= pattern_len) begin
      if (match) begin
        sh = pattern_len;
      end else begin
        emit_char = 1'b1;
        sh        = CNT_W'(1);
      end
    end else if (last_now && (cur_cnt != '0)) begin
      emit_char = 1'b1;
      sh        = CNT_W'(1);
    end

    cnt_next = cur_cnt - sh;

    for (int i = 0; i < PATTERN_MAX; i++) begin
      src = SUM_W'(i) + SUM_W'(sh);
      if (src < SUM_W'(PATTERN_MAX)) begin
        win_next[i] = cur_win[src[SLOT_W-1:0]];
      end else begin
        win_next[i] = cur_win[i];
      end
    end

    if (pattern_len == '0) begin
      more = (cnt_next != '0);
    end else begin
      more = (cnt_next >= pattern_len);
    end
    more = more || (last_now && (cnt_next != '0));
    done = !more;

    empty_mark = done && last_now && !emit_char && !emitted_before;
    emit       = active && (emit_char || empty_mark);

    emit_item.out_char    = empty_mark ? 8'h00 : cur_win[0];
    emit_item.char_valid  = !empty_mark;
    emit_item.end_of_text = done && last_now;

    push_need = hold_valid && (emit || hold_final);
    stall     = push_need && res_full;
    advance   = active && !stall;
    in_pop    = advance && !busy;
    res_push  = push_need && !res_full;
    res_item  = hold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= '0;
      busy         <= 1'b0;
      item_last    <= 1'b0;
      item_emitted <= 1'b0;
      hold_valid   <= 1'b0;
      hold_final   <= 1'b0;
    end else begin
      if (advance) begin
        cnt          <= cnt_next;
        busy         <= !done;
        item_last    <= last_now;
        item_emitted <= emitted_before || emit;
      end
      if (!stall) begin
        if (emit) begin
          hold_valid <= 1'b1;
          hold_final <= done;
        end else if (push_need) begin
          hold_valid <= 1'b0;
          hold_final <= 1'b0;
        end else if (active && done && hold_valid) begin
          hold_final <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      win <= win_next;
    end
    if (!stall) begin
      if (emit) begin
        hold <= emit_item;
      end else if (!push_need && active && done && hold_valid) begin
        hold.end_of_text <= last_now;
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/sdf_out_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdf_out_queue
// Result queue between the scan engine and the consumer.
// ----------------------------------------------------------------------------
module sdf_out_queue import sdf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    wr_en,
  input  result_t wr_item,
  output logic    full,
  output logic    avail,
  input  logic    rd_en,
  output result_t rd_item
);

  result_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_wr;
  logic                do_rd;

  always_comb begin
    full    = (count == QCNT_W'(QUEUE_DEPTH));
    avail   = (count != '0);
    do_wr   = wr_en && !full;
    do_rd   = rd_en && avail;
    rd_item = slots[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_item;
    end
  end

endmodule
`default_nettype wire

FILE: design/substring_delete_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// substring_delete_filter
// Deletes every non-overlapping occurrence of a configured pattern from a
// character stream, found greedily from the left.
//
//   Channel   Handshake            Payload
//   input     push / full          text_char, is_last
//   result    empty / pop          out_char, char_valid, end_of_text
//   config    cfg_we               cfg_addr, cfg_wdata
//
// One character per cycle is sustained while the result queue has room; each
// takes one scan step that compares the whole window with the pattern in
// parallel. No new character is taken while the engine flushes the pending
// characters after the last one of a text, or takes extra window steps after
// a pattern change. Reset clears the queues, the window count and the
// pattern registers. Either side may stall at any time; the queues let the
// other side keep going until they fill.
// ----------------------------------------------------------------------------
module substring_delete_filter import sdf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [7:0]       text_char,
  input  logic             is_last,
  output logic             empty,
  input  logic             pop,
  output logic [7:0]       out_char,
  output logic             char_valid,
  output logic             end_of_text,
  input  logic             cfg_we,
  input  logic             cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata
);

  logic [PATTERN_MAX*8-1:0] pattern_bytes;
  logic [LEN_W-1:0]         pattern_length;
  logic [CNT_W-1:0]         pattern_len;

  in_item_t wr_in;
  in_item_t rd_in;
  logic     in_avail;
  logic     in_pop;
  logic     res_push;
  result_t  res_item;
  logic     res_full;
  logic     res_avail;
  result_t  head;

  always_comb begin
    wr_in.text_char = text_char;
    wr_in.is_last   = is_last;
    if (pattern_length > LEN_W'(PATTERN_MAX)) begin
      pattern_len = CNT_W'(PATTERN_MAX);
    end else begin
      pattern_len = CNT_W'(pattern_length);
    end
    empty       = !res_avail;
    out_char    = head.out_char;
    char_valid  = head.char_valid;
    end_of_text = head.end_of_text;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= '0;
      pattern_length <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PATTERN_BYTES:  pattern_bytes  <= cfg_wdata[PATTERN_MAX*8-1:0];
        REG_PATTERN_LENGTH: pattern_length <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  sdf_front u_front (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_item (wr_in),
    .full    (full),
    .avail   (in_avail),
    .rd_en   (in_pop),
    .rd_item (rd_in)
  );

  sdf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .pattern_bytes (pattern_bytes),
    .pattern_len   (pattern_len),
    .in_avail      (in_avail),
    .in_item       (rd_in),
    .in_pop        (in_pop),
    .res_push      (res_push),
    .res_item      (res_item),
    .res_full      (res_full)
  );

  sdf_out_queue u_out_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_item (res_item),
    .full    (res_full),
    .avail   (res_avail),
    .rd_en   (pop),
    .rd_item (head)
  );

endmodule
`default_nettype wire
